>>> src/gmo_pkg.sv
// ----------------------------------------------------------------------------
// gmo_pkg
// Shared constants, types and helper functions of the gliding multiwave
// oscillator: widths, waveform and register codes, sine table builder.
// ----------------------------------------------------------------------------
package gmo_pkg;

  localparam int PHASE_BITS       = 32;
  localparam int SAMPLE_BITS      = 16;
  localparam int SINE_TABLE_DEPTH = 1024;  // power of two

  localparam int TARGET_BITS = 32;
  localparam int PM_BITS     = 16;
  localparam int DEPTH_BITS  = 16;
  localparam int WF_BITS     = 3;
  localparam int PROD_BITS   = DEPTH_BITS + 1 + PM_BITS;

  localparam int MOD_FRAC_BITS   = 27;
  localparam int GLIDE_MUL       = 16777;
  localparam int GLIDE_MUL_BITS  = 15;
  localparam int GLIDE_SHIFT     = 25;
  localparam int GLIDE_PROD_BITS = PHASE_BITS + GLIDE_MUL_BITS;

  localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int ROM_ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);

  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint ONE_Q30      = 64'sd1 << 30;
  localparam longint HALF_Q30     = ONE_Q30 / 2;
  localparam longint SINE_DEPTH_L = longint'(SINE_TABLE_DEPTH);
  localparam longint HALF_SCALE   = 64'sd1 << (SAMPLE_BITS - 1);
  localparam longint SMAX         = HALF_SCALE - 1;

  // Taylor term divisors (2n)(2n+1)
  localparam longint TAYLOR_DEN [1:12] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                           64'sd110, 64'sd156, 64'sd210, 64'sd272,
                                           64'sd342, 64'sd420, 64'sd506, 64'sd600};

  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic [ROM_ADDR_BITS-1:0]      rom_addr_t;
  typedef logic [SAMPLE_BITS-2:0]        rom_data_t;
  typedef rom_data_t sine_table_t [0:SINE_TABLE_DEPTH];

  localparam phase_t RESET_INC =
    PHASE_BITS'(((longint'(440) << PHASE_BITS) + 24000) / 48000);
  // base is kept one increment behind the live phase
  localparam phase_t PHASE_BASE_RESET = phase_t'(0) - RESET_INC;

  localparam logic [WF_BITS-1:0] WF_SINE     = WF_BITS'(0);
  localparam logic [WF_BITS-1:0] WF_SAW_UP   = WF_BITS'(1);
  localparam logic [WF_BITS-1:0] WF_SAW_DOWN = WF_BITS'(2);
  localparam logic [WF_BITS-1:0] WF_SQUARE   = WF_BITS'(3);
  localparam logic [WF_BITS-1:0] WF_TRIANGLE = WF_BITS'(4);

  localparam int                    APB_ADDR_BITS   = 3;
  localparam logic                  REG_MOD_DEPTH   = 1'b0;
  localparam logic [DEPTH_BITS-1:0] MOD_DEPTH_RESET = DEPTH_BITS'(4096);

  typedef struct packed {
    logic      neg;
    logic      is_sine;
    rom_addr_t addr;
    sample_t   other;
  } shape_t;

  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    longint      x;
    longint      s;
    longint      t;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = HALF_PI_Q30 * longint'(i) / SINE_DEPTH_L;
      s = x;
      t = x;
      for (int n = 1; n <= 12; n++) begin
        t = t * x / ONE_Q30;
        t = t * x / ONE_Q30;
        t = -t / TAYLOR_DEN[n];
        s = s + t;
      end
      if (s < 0) s = 0;
      if (s > ONE_Q30) s = ONE_Q30;
      tbl[i] = rom_data_t'((s * SMAX + HALF_Q30) / ONE_Q30);
    end
    return tbl;
  endfunction

  // turns in 2^-MOD_FRAC_BITS units to phase units, modulo one turn
  function automatic phase_t mod_offset(input prod_t prod);
    logic signed [PROD_BITS+PHASE_BITS-1:0] wide;
    wide = (PROD_BITS + PHASE_BITS)'(prod);
    if (PHASE_BITS >= MOD_FRAC_BITS)
      return PHASE_BITS'(wide <<< (PHASE_BITS - MOD_FRAC_BITS));
    else
      return PHASE_BITS'(wide >>> (MOD_FRAC_BITS - PHASE_BITS));
  endfunction

endpackage

>>> src/gmo_in_if.sv
// ----------------------------------------------------------------------------
// gmo_in_if
// Request channel into the oscillator: one sample tick per request.
// ----------------------------------------------------------------------------
interface gmo_in_if import gmo_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [TARGET_BITS-1:0]     target_increment;
  logic signed [PM_BITS-1:0]  phase_mod;
  logic [WF_BITS-1:0]         waveform;

  modport source (output valid, target_increment, phase_mod, waveform, input ready);
  modport sink   (input valid, target_increment, phase_mod, waveform, output ready);
endinterface

>>> src/gmo_out_if.sv
// ----------------------------------------------------------------------------
// gmo_out_if
// Result channel out of the oscillator: one sample per request.
// ----------------------------------------------------------------------------
interface gmo_out_if import gmo_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

>>> src/gmo_sine_rom.sv
// ----------------------------------------------------------------------------
// gmo_sine_rom
// Quarter-wave sine ROM, SINE_TABLE_DEPTH + 1 entries, registered read.
// ----------------------------------------------------------------------------
module gmo_sine_rom import gmo_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  rom_addr_t addr,
  output rom_data_t data
);

  localparam sine_table_t SINE_ROM = build_sine_table();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= SINE_ROM[addr];
    end
  end

endmodule

>>> src/gmo_phase_glide.sv
// ----------------------------------------------------------------------------
// gmo_phase_glide
// Phase accumulator and increment glide. The live phase is base + increment,
// so the glide and the phase add sit in separate register loops.
// ----------------------------------------------------------------------------
module gmo_phase_glide import gmo_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [TARGET_BITS-1:0] target,
  output phase_t                 phase_now
);

  phase_t                     phase_base;
  phase_t                     cur;
  phase_t                     cur_next;
  phase_t                     tgt;
  phase_t                     step;
  phase_t                     diff;
  logic [GLIDE_PROD_BITS-1:0] glide_prod;

  assign phase_now = phase_base + cur;
  assign tgt       = PHASE_BITS'(target);

  always_comb begin
    glide_prod = GLIDE_PROD_BITS'(cur) * GLIDE_PROD_BITS'(GLIDE_MUL);
    step       = PHASE_BITS'(glide_prod[GLIDE_PROD_BITS-1:GLIDE_SHIFT]);
    if (step == '0) step = phase_t'(1);
    diff = (cur > tgt) ? cur - tgt : tgt - cur;
    priority if (diff < step) begin
      cur_next = tgt;
    end else if (cur < tgt) begin
      cur_next = cur + step;
    end else begin
      cur_next = cur - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_base <= PHASE_BASE_RESET;
      cur        <= RESET_INC;
    end else if (advance) begin
      phase_base <= phase_now;
      cur        <= cur_next;
    end
  end

endmodule

>>> src/gmo_wave_shaper.sv
// ----------------------------------------------------------------------------
// gmo_wave_shaper
// Applies the modulation offset (sine and saw only) and forms the saw, square
// and triangle samples plus the sine ROM address and sign.
// ----------------------------------------------------------------------------
module gmo_wave_shaper import gmo_pkg::*; (
  input  phase_t             phase_now,
  input  prod_t              prod,
  input  logic [WF_BITS-1:0] waveform,
  output shape_t             shape
);

  localparam logic signed [SAMPLE_BITS+1:0] HALF = (SAMPLE_BITS + 2)'(HALF_SCALE);
  localparam logic signed [SAMPLE_BITS+1:0] PEAK = (SAMPLE_BITS + 2)'(SMAX);

  phase_t                        pp;
  logic [1:0]                    quad;
  logic [SINE_IDX_BITS-1:0]      idx;
  logic [SAMPLE_BITS-1:0]        saw_u;
  logic [SAMPLE_BITS:0]          tri_u;
  logic signed [SAMPLE_BITS+1:0] rise;
  logic signed [SAMPLE_BITS+1:0] fall;
  logic signed [SAMPLE_BITS+1:0] tri_v;

  always_comb begin
    pp    = phase_now + mod_offset(prod);
    quad  = pp[PHASE_BITS-1 -: 2];
    idx   = pp[PHASE_BITS-3 -: SINE_IDX_BITS];
    saw_u = pp[PHASE_BITS-1 -: SAMPLE_BITS];
    tri_u = phase_now[PHASE_BITS-1 -: SAMPLE_BITS+1];

    rise = $signed({2'b00, saw_u}) - HALF;
    fall = HALF - $signed({2'b00, saw_u});
    if (fall > PEAK) fall = PEAK;

    if (!tri_u[SAMPLE_BITS]) begin
      tri_v = $signed({1'b0, tri_u}) - HALF;
    end else begin
      tri_v = HALF + HALF + HALF - $signed({1'b0, tri_u});
    end
    if (tri_v > PEAK) tri_v = PEAK;

    shape.neg     = quad[1];
    shape.is_sine = (waveform == WF_SINE);
    shape.addr    = quad[0] ? ROM_ADDR_BITS'(SINE_TABLE_DEPTH) - ROM_ADDR_BITS'(idx)
                            : ROM_ADDR_BITS'(idx);

    unique case (waveform)
      WF_SINE:     shape.other = '0;
      WF_SAW_UP:   shape.other = SAMPLE_BITS'(rise);
      WF_SAW_DOWN: shape.other = SAMPLE_BITS'(fall);
      WF_SQUARE:   shape.other = phase_now[PHASE_BITS-1] ? sample_t'(SMAX)
                                                         : sample_t'(-HALF_SCALE);
      WF_TRIANGLE: shape.other = SAMPLE_BITS'(tri_v);
      default:     shape.other = '0;
    endcase
  end

endmodule

>>> src/gliding_multiwave_oscillator_core.sv
// ----------------------------------------------------------------------------
// gliding_multiwave_oscillator_core
// Phase-accumulator oscillator with increment glide, phase modulation and
// five waveforms, fed by a request channel and an APB register port.
// A request passes the stage 1, 2 and 3 registers, then the output register.
// Throughput: one request per cycle; ready drops only when the pipe is full
// and the result is stalled. Synchronous reset clears all stage valids, sets
// phase 0, increment to 440 Hz at 48 kHz and mod_depth to 4096.
// ----------------------------------------------------------------------------
module gliding_multiwave_oscillator_core import gmo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  gmo_in_if.sink                   din,
  gmo_out_if.source                dout,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [DEPTH_BITS-1:0] mod_depth;

  // stage 1: request register
  logic                      s1_valid;
  logic [TARGET_BITS-1:0]    s1_target;
  logic signed [PM_BITS-1:0] s1_pm;
  logic [WF_BITS-1:0]        s1_wf;
  // stage 2: phase and modulation product
  logic                      s2_valid;
  phase_t                    s2_phase;
  prod_t                     s2_prod;
  logic [WF_BITS-1:0]        s2_wf;
  // stage 3: rom data and shaped samples
  logic                      s3_valid;
  logic                      s3_neg;
  logic                      s3_is_sine;
  sample_t                   s3_other;
  rom_data_t                 s3_rom;
  // output register
  logic                      o_valid;
  sample_t                   o_sample;

  logic    load_o, load3, load2, load1;
  phase_t  phase_now;
  prod_t   prod;
  shape_t  shape;
  sample_t sine_mag;
  sample_t s3_sample;

  assign load_o = !o_valid || dout.ready;
  assign load3  = !s3_valid || load_o;
  assign load2  = !s2_valid || load3;
  assign load1  = !s1_valid || load2;

  assign din.ready   = load1;
  assign dout.valid  = o_valid;
  assign dout.sample = o_sample;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_BITS-1:2] == REG_MOD_DEPTH) ? 32'(mod_depth) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_depth <= MOD_DEPTH_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[APB_ADDR_BITS-1:2] == REG_MOD_DEPTH) begin
      mod_depth <= pwdata[DEPTH_BITS-1:0];
    end
  end

  gmo_phase_glide u_glide (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_valid && load2),
    .target    (s1_target),
    .phase_now (phase_now)
  );

  assign prod = $signed({1'b0, mod_depth}) * s1_pm;

  gmo_wave_shaper u_shaper (
    .phase_now (s2_phase),
    .prod      (s2_prod),
    .waveform  (s2_wf),
    .shape     (shape)
  );

  gmo_sine_rom u_rom (
    .clk  (clk),
    .en   (load3),
    .addr (shape.addr),
    .data (s3_rom)
  );

  assign sine_mag  = sample_t'({1'b0, s3_rom});
  assign s3_sample = s3_is_sine ? (s3_neg ? -sine_mag : sine_mag) : s3_other;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (load1)  s1_valid <= din.valid;
      if (load2)  s2_valid <= s1_valid;
      if (load3)  s3_valid <= s2_valid;
      if (load_o) o_valid  <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_target <= din.target_increment;
      s1_pm     <= din.phase_mod;
      s1_wf     <= din.waveform;
    end
    if (load2) begin
      s2_phase <= phase_now;
      s2_prod  <= prod;
      s2_wf    <= s1_wf;
    end
    if (load3) begin
      s3_neg     <= shape.neg;
      s3_is_sine <= shape.is_sine;
      s3_other   <= shape.other;
    end
    if (load_o) begin
      o_sample <= s3_sample;
    end
  end

endmodule
